FILE: hw/rtl/u8v16_pkg.sv
// package: types, constants and decode tables for the utf-8 validator and utf-16 counter
`default_nettype none

package u8v16_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int CODE_WIDTH = 21;
	localparam int TOTAL_WIDTH = 32;

	localparam logic [3:0] ST_ACCEPT = 4'd0;
	localparam logic [3:0] ST_REJECT = 4'd1;
	localparam logic [3:0] ST_TWO = 4'd2;
	localparam logic [3:0] ST_THREE = 4'd3;
	localparam logic [3:0] ST_E0 = 4'd4;
	localparam logic [3:0] ST_ED = 4'd5;
	localparam logic [3:0] ST_F0 = 4'd6;
	localparam logic [3:0] ST_F1 = 4'd7;
	localparam logic [3:0] ST_F4 = 4'd8;

	localparam logic [3:0] CL_ASCII = 4'd0;
	localparam logic [3:0] CL_CONT_LO = 4'd1;
	localparam logic [3:0] CL_LEAD2 = 4'd2;
	localparam logic [3:0] CL_LEAD3 = 4'd3;
	localparam logic [3:0] CL_ED = 4'd4;
	localparam logic [3:0] CL_F4 = 4'd5;
	localparam logic [3:0] CL_LEAD4 = 4'd6;
	localparam logic [3:0] CL_CONT_HI = 4'd7;
	localparam logic [3:0] CL_BAD = 4'd8;
	localparam logic [3:0] CL_CONT_MID = 4'd9;
	localparam logic [3:0] CL_E0 = 4'd10;
	localparam logic [3:0] CL_F0 = 4'd11;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} u8v16_in_t;

	typedef struct packed {
		logic [CODE_WIDTH-1:0]  code_point;
		logic                   code_ready;
		logic                   needs_pair;
		logic                   rejected;
		logic                   done_res;
		logic                   bad_string;
		logic [TOTAL_WIDTH-1:0] unit_total;
	} u8v16_out_t;

	function automatic logic [3:0] byte_class(input logic [7:0] b);
		logic [3:0] cls;
		cls = CL_BAD;
		unique case (b) inside
			[8'h00:8'h7F]: cls = CL_ASCII;
			[8'h80:8'h8F]: cls = CL_CONT_LO;
			[8'h90:8'h9F]: cls = CL_CONT_MID;
			[8'hA0:8'hBF]: cls = CL_CONT_HI;
			[8'hC0:8'hC1]: cls = CL_BAD;
			[8'hC2:8'hDF]: cls = CL_LEAD2;
			8'hE0:         cls = CL_E0;
			[8'hE1:8'hEC]: cls = CL_LEAD3;
			8'hED:         cls = CL_ED;
			[8'hEE:8'hEF]: cls = CL_LEAD3;
			8'hF0:         cls = CL_F0;
			[8'hF1:8'hF3]: cls = CL_LEAD4;
			8'hF4:         cls = CL_F4;
			default:       cls = CL_BAD;
		endcase
		return cls;
	endfunction

	function automatic logic [3:0] dfa_next(input logic [3:0] st, input logic [3:0] cls);
		logic [3:0] nxt;
		nxt = ST_REJECT;
		unique case (st)
			ST_ACCEPT: begin
				unique case (cls)
					CL_ASCII:  nxt = ST_ACCEPT;
					CL_LEAD2:  nxt = ST_TWO;
					CL_LEAD3:  nxt = ST_THREE;
					CL_ED:     nxt = ST_ED;
					CL_F4:     nxt = ST_F4;
					CL_LEAD4:  nxt = ST_F1;
					CL_E0:     nxt = ST_E0;
					CL_F0:     nxt = ST_F0;
					default:   nxt = ST_REJECT;
				endcase
			end
			ST_TWO: begin
				unique case (cls) inside
					CL_CONT_LO, CL_CONT_HI, CL_CONT_MID: nxt = ST_ACCEPT;
					default:                             nxt = ST_REJECT;
				endcase
			end
			ST_THREE: begin
				unique case (cls) inside
					CL_CONT_LO, CL_CONT_HI, CL_CONT_MID: nxt = ST_TWO;
					default:                             nxt = ST_REJECT;
				endcase
			end
			ST_E0: begin
				unique case (cls)
					CL_CONT_HI: nxt = ST_TWO;
					default:    nxt = ST_REJECT;
				endcase
			end
			ST_ED: begin
				unique case (cls) inside
					CL_CONT_LO, CL_CONT_MID: nxt = ST_TWO;
					default:                 nxt = ST_REJECT;
				endcase
			end
			ST_F0: begin
				unique case (cls) inside
					CL_CONT_HI, CL_CONT_MID: nxt = ST_THREE;
					default:                 nxt = ST_REJECT;
				endcase
			end
			ST_F1: begin
				unique case (cls) inside
					CL_CONT_LO, CL_CONT_HI, CL_CONT_MID: nxt = ST_THREE;
					default:                             nxt = ST_REJECT;
				endcase
			end
			ST_F4: begin
				unique case (cls)
					CL_CONT_LO: nxt = ST_THREE;
					default:    nxt = ST_REJECT;
				endcase
			end
			default: nxt = ST_REJECT;
		endcase
		return nxt;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/utf8_validate_utf16_count.sv
// top level: utf-8 validating decoder with saturating utf-16 unit count
// path: an input beat goes through the input register and then the result register
// throughput: one byte per cycle unless the result side stalls; the dfa step is one class lookup and one table lookup
// a full result register that the receiver is not taking stalls the input stage, which in turn drops item_ready
// reset: dfa in accept, partial code zero, unit count one, both stages empty
// an end beat reports the total or the error and returns the decoder to its reset state
`default_nettype none

module utf8_validate_utf16_count (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire u8v16_pkg::u8v16_in_t  item,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output u8v16_pkg::u8v16_out_t      result
);

	localparam int CW = u8v16_pkg::COUNT_WIDTH;
	localparam int EXT_W = CW + u8v16_pkg::TOTAL_WIDTH + 1;

	logic                  valid_s1;
	u8v16_pkg::u8v16_in_t  item_s1;
	logic                  advance;

	logic [3:0]                          dfa_q;
	logic [u8v16_pkg::CODE_WIDTH-1:0]    partial_q;
	logic [CW-1:0]                       count_q;

	logic [3:0]                          st_cur;
	logic [3:0]                          cls;
	logic [3:0]                          st_nxt;
	logic [7:0]                          lead_mask;
	logic [u8v16_pkg::CODE_WIDTH-1:0]    partial_nxt;
	logic                                pair;
	logic [CW:0]                         count_sum;
	logic [CW-1:0]                       count_sat;
	logic [EXT_W-1:0]                    count_ext;
	u8v16_pkg::u8v16_out_t               res_nxt;

	assign advance = valid_s1 && (!result_valid || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// decode step
	always_comb begin
		st_cur = (dfa_q > u8v16_pkg::ST_F4) ? u8v16_pkg::ST_REJECT : dfa_q;
		cls = u8v16_pkg::byte_class(item_s1.data_byte);
		st_nxt = u8v16_pkg::dfa_next(st_cur, cls);
		lead_mask = 8'hFF >> cls;
		if (st_cur != u8v16_pkg::ST_ACCEPT) begin
			partial_nxt = {partial_q[u8v16_pkg::CODE_WIDTH-7:0], item_s1.data_byte[5:0]};
		end else begin
			partial_nxt = {{(u8v16_pkg::CODE_WIDTH-8){1'b0}}, lead_mask & item_s1.data_byte};
		end
		pair = partial_nxt > u8v16_pkg::CODE_WIDTH'(16'hFFFF);
		count_sum = {1'b0, count_q} + {{(CW-1){1'b0}}, pair, !pair};
		count_sat = count_sum[CW] ? {CW{1'b1}} : count_sum[CW-1:0];
		count_ext = {{(EXT_W-CW){1'b0}}, count_q};

		res_nxt = '0;
		if (item_s1.end_of_string) begin
			res_nxt.rejected = (st_cur == u8v16_pkg::ST_REJECT);
			res_nxt.done_res = 1'b1;
			res_nxt.bad_string = (st_cur != u8v16_pkg::ST_ACCEPT);
			if (st_cur == u8v16_pkg::ST_ACCEPT) begin
				res_nxt.unit_total = count_ext[u8v16_pkg::TOTAL_WIDTH-1:0];
			end
		end else begin
			res_nxt.rejected = (st_nxt == u8v16_pkg::ST_REJECT);
			if (st_nxt == u8v16_pkg::ST_ACCEPT) begin
				res_nxt.code_point = partial_nxt;
				res_nxt.code_ready = 1'b1;
				res_nxt.needs_pair = pair;
			end
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dfa_q <= u8v16_pkg::ST_ACCEPT;
			partial_q <= '0;
			count_q <= CW'(1);
		end else if (advance) begin
			if (item_s1.end_of_string) begin
				dfa_q <= u8v16_pkg::ST_ACCEPT;
				partial_q <= '0;
				count_q <= CW'(1);
			end else begin
				dfa_q <= st_nxt;
				partial_q <= partial_nxt;
				if (st_nxt == u8v16_pkg::ST_ACCEPT) begin
					count_q <= count_sat;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result <= res_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: verif/tb_utf8_validate_utf16_count.sv
// testbench: utf-8 dfa decode and utf-16 unit count checked beat by beat against a local predictor
`timescale 1ns / 100ps

module tb_utf8_validate_utf16_count;

	localparam int NUM_ITEMS = 600;
	localparam int CYCLE_LIMIT = 200000;
	localparam int CNT_W = u8v16_pkg::COUNT_WIDTH;
	localparam int CODE_W = u8v16_pkg::CODE_WIDTH;
	localparam int TOTAL_W = u8v16_pkg::TOTAL_WIDTH;
	localparam logic [CNT_W-1:0] UNITS_MAX = '1;

	typedef struct {
		u8v16_pkg::u8v16_in_t beat;
		bit                   drain_first;
	} queued_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	u8v16_pkg::u8v16_in_t  item = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	u8v16_pkg::u8v16_out_t result;

	queued_beat_t          byte_q[$];
	u8v16_pkg::u8v16_out_t decoded_q[$];

	logic [3:0]        dec_state = u8v16_pkg::ST_ACCEPT;
	logic [CODE_W-1:0] dec_bits = '0;
	logic [CNT_W-1:0]  dec_units = 1;

	bit drain_next = 1'b0;
	int queued = 0;
	int results_seen = 0;
	int mismatches = 0;
	int cycles = 0;
	bit in_fire = 1'b0;
	bit out_fire = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;

	utf8_validate_utf16_count dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [3:0] char_class(input logic [7:0] b);
		if (b < 8'h80) return u8v16_pkg::CL_ASCII;
		if (b < 8'h90) return u8v16_pkg::CL_CONT_LO;
		if (b < 8'hA0) return u8v16_pkg::CL_CONT_MID;
		if (b < 8'hC0) return u8v16_pkg::CL_CONT_HI;
		if (b < 8'hC2) return u8v16_pkg::CL_BAD;
		if (b < 8'hE0) return u8v16_pkg::CL_LEAD2;
		if (b == 8'hE0) return u8v16_pkg::CL_E0;
		if (b == 8'hED) return u8v16_pkg::CL_ED;
		if (b < 8'hF0) return u8v16_pkg::CL_LEAD3;
		if (b == 8'hF0) return u8v16_pkg::CL_F0;
		if (b < 8'hF4) return u8v16_pkg::CL_LEAD4;
		if (b == 8'hF4) return u8v16_pkg::CL_F4;
		return u8v16_pkg::CL_BAD;
	endfunction

	function automatic logic [3:0] dfa_advance(input logic [3:0] st, input logic [3:0] cls);
		logic lo, mid, hi;
		lo = (cls == u8v16_pkg::CL_CONT_LO);
		mid = (cls == u8v16_pkg::CL_CONT_MID);
		hi = (cls == u8v16_pkg::CL_CONT_HI);
		case (st)
			u8v16_pkg::ST_ACCEPT: begin
				case (cls)
					u8v16_pkg::CL_ASCII: return u8v16_pkg::ST_ACCEPT;
					u8v16_pkg::CL_LEAD2: return u8v16_pkg::ST_TWO;
					u8v16_pkg::CL_LEAD3: return u8v16_pkg::ST_THREE;
					u8v16_pkg::CL_ED:    return u8v16_pkg::ST_ED;
					u8v16_pkg::CL_F4:    return u8v16_pkg::ST_F4;
					u8v16_pkg::CL_LEAD4: return u8v16_pkg::ST_F1;
					u8v16_pkg::CL_E0:    return u8v16_pkg::ST_E0;
					u8v16_pkg::CL_F0:    return u8v16_pkg::ST_F0;
					default:             return u8v16_pkg::ST_REJECT;
				endcase
			end
			u8v16_pkg::ST_TWO:   if (lo || mid || hi) return u8v16_pkg::ST_ACCEPT;
			u8v16_pkg::ST_THREE: if (lo || mid || hi) return u8v16_pkg::ST_TWO;
			u8v16_pkg::ST_E0:    if (hi) return u8v16_pkg::ST_TWO;
			u8v16_pkg::ST_ED:    if (lo || mid) return u8v16_pkg::ST_TWO;
			u8v16_pkg::ST_F0:    if (mid || hi) return u8v16_pkg::ST_THREE;
			u8v16_pkg::ST_F1:    if (lo || mid || hi) return u8v16_pkg::ST_THREE;
			u8v16_pkg::ST_F4:    if (lo) return u8v16_pkg::ST_THREE;
			default:             return u8v16_pkg::ST_REJECT;
		endcase
		return u8v16_pkg::ST_REJECT;
	endfunction

	function automatic u8v16_pkg::u8v16_out_t decode_byte(input u8v16_pkg::u8v16_in_t beat);
		u8v16_pkg::u8v16_out_t r;
		logic [3:0] cls;
		logic [CNT_W-1:0] add;
		r = '0;
		if (beat.end_of_string) begin
			r.rejected = (dec_state == u8v16_pkg::ST_REJECT);
			r.done_res = 1'b1;
			if (dec_state != u8v16_pkg::ST_ACCEPT)
				r.bad_string = 1'b1;
			else
				r.unit_total = TOTAL_W'(dec_units);
			dec_state = u8v16_pkg::ST_ACCEPT;
			dec_bits = '0;
			dec_units = 1;
			return r;
		end
		cls = char_class(beat.data_byte);
		if (dec_state != u8v16_pkg::ST_ACCEPT)
			dec_bits = {dec_bits[CODE_W-7:0], beat.data_byte[5:0]};
		else
			dec_bits = CODE_W'((8'hFF >> cls) & beat.data_byte);
		dec_state = dfa_advance(dec_state, cls);
		if (dec_state == u8v16_pkg::ST_ACCEPT) begin
			add = (dec_bits > 'hFFFF) ? 2 : 1;
			if (dec_units > UNITS_MAX - add)
				dec_units = UNITS_MAX;
			else
				dec_units = dec_units + add;
			r.code_point = dec_bits;
			r.code_ready = 1'b1;
			r.needs_pair = (add == 2);
		end
		r.rejected = (dec_state == u8v16_pkg::ST_REJECT);
		return r;
	endfunction

	task automatic push_beat(input logic [7:0] b, input logic eos);
		queued_beat_t q;
		q.beat.data_byte = b;
		q.beat.end_of_string = eos;
		q.drain_first = drain_next;
		drain_next = 1'b0;
		byte_q.push_back(q);
		queued++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		push_beat(b, 1'b0);
	endtask

	task automatic push_end();
		push_beat(8'($urandom), 1'b1);
	endtask

	// utf-8 encode; drop_last leaves the sequence one byte short
	task automatic push_scalar(input logic [20:0] cp, input bit drop_last);
		logic [7:0] seq[$];
		if (cp < 'h80) begin
			seq.push_back(cp[7:0]);
		end else if (cp < 'h800) begin
			seq.push_back({3'b110, cp[10:6]});
			seq.push_back({2'b10, cp[5:0]});
		end else if (cp < 'h10000) begin
			seq.push_back({4'b1110, cp[15:12]});
			seq.push_back({2'b10, cp[11:6]});
			seq.push_back({2'b10, cp[5:0]});
		end else begin
			seq.push_back({5'b11110, cp[20:18]});
			seq.push_back({2'b10, cp[17:12]});
			seq.push_back({2'b10, cp[11:6]});
			seq.push_back({2'b10, cp[5:0]});
		end
		if (drop_last)
			void'(seq.pop_back());
		foreach (seq[i])
			push_byte(seq[i]);
	endtask

	function automatic logic [20:0] random_scalar(input int min_len);
		logic [20:0] cp;
		case ($urandom_range(min_len, 3))
			0: cp = 21'($urandom_range(0, 'h7F));
			1: cp = 21'($urandom_range('h80, 'h7FF));
			2: begin
				cp = 21'($urandom_range('h800, 'hFFFF));
				if (cp >= 'hD800 && cp <= 'hDFFF)
					cp = cp ^ 21'h2000;
			end
			default: cp = 21'($urandom_range('h10000, 'h10FFFF));
		endcase
		return cp;
	endfunction

	task automatic check_field(input string fname, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result beat %0d: %s expected %0h got %0h", results_seen, fname, want, got);
		end
	endtask

	// sender
	always @(negedge clk) begin : driver
		queued_beat_t nxt;
		logic nv;
		if (arst_n && (!item_valid || in_fire)) begin
			nv = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (byte_q.size() != 0 &&
					!(byte_q[0].drain_first && decoded_q.size() != 0)) begin
				nxt = byte_q.pop_front();
				item <= nxt.beat;
				nv = 1'b1;
				if ($urandom_range(0, 31) == 0)
					send_idle = !send_idle;
				send_gap = send_idle ? $urandom_range(0, 3) : 0;
			end
			item_valid <= nv;
		end
	end

	// receiver
	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (out_fire) begin
				if ($urandom_range(0, 31) == 0)
					recv_idle = !recv_idle;
				stall_left = recv_idle ? $urandom_range(0, 3) : 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : monitor
		u8v16_pkg::u8v16_out_t want;
		cycles++;
		in_fire = arst_n && item_valid && item_ready;
		out_fire = arst_n && result_valid && result_ready;
		if (in_fire)
			decoded_q.push_back(decode_byte(item));
		if (out_fire) begin
			results_seen++;
			if (decoded_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result beat %0d: unexpected, nothing predicted", results_seen);
			end else begin
				want = decoded_q.pop_front();
				check_field("code_point", 32'(want.code_point), 32'(result.code_point));
				check_field("code_ready", 32'(want.code_ready), 32'(result.code_ready));
				check_field("needs_pair", 32'(want.needs_pair), 32'(result.needs_pair));
				check_field("rejected", 32'(want.rejected), 32'(result.rejected));
				check_field("done_res", 32'(want.done_res), 32'(result.done_res));
				check_field("bad_string", 32'(want.bad_string), 32'(result.bad_string));
				check_field("unit_total", 32'(want.unit_total), 32'(result.unit_total));
			end
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT)
			@(posedge clk);
		$display("utf8_validate_utf16_count verification failed");
		$finish;
	end

	initial begin : stimulus
		int kind;
		int nchars;
		// ascii extremes, zero byte, shortest two-byte form
		push_byte(8'h00);
		push_byte(8'h7F);
		push_scalar(21'h80, 1'b0);
		push_end();
		// lowest three-byte and highest four-byte scalars
		push_scalar(21'h800, 1'b0);
		push_scalar(21'h10FFFF, 1'b0);
		push_end();
		// empty string
		push_end();
		// surrogate lead rejects and stays rejected
		push_byte(8'hED);
		push_byte(8'hA0);
		push_byte(8'h41);
		push_end();
		// truncated four-byte sequence
		push_byte(8'hF0);
		push_byte(8'h90);
		push_end();
		// invalid byte and stray continuation
		push_byte(8'hFF);
		push_end();
		push_byte(8'h80);
		push_end();

		drain_next = 1'b1;
		while (queued < NUM_ITEMS) begin
			if ($urandom_range(0, 49) == 0)
				drain_next = 1'b1;
			kind = $urandom_range(0, 9);
			nchars = $urandom_range(0, 6);
			for (int i = 0; i < nchars; i++)
				push_scalar(random_scalar(0), 1'b0);
			if (kind == 7) begin
				repeat ($urandom_range(1, 6))
					push_byte(8'($urandom));
			end else if (kind == 8) begin
				push_scalar(random_scalar(1), 1'b1);
			end else if (kind == 9) begin
				push_scalar(random_scalar(1), 1'b1);
				push_byte(8'($urandom));
				push_scalar(random_scalar(0), 1'b0);
			end
			push_end();
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (byte_q.size() != 0 || item_valid || decoded_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("utf8_validate_utf16_count verification clean");
		else
			$display("utf8_validate_utf16_count verification failed");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/u8v16_pkg.sv
hw/rtl/utf8_validate_utf16_count.sv
verif/tb_utf8_validate_utf16_count.sv
